[design/dq_pkg.sv]
`default_nettype none
package dq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [1:0] {
      MODE_PUSH_BACK  = 2'd0,
      MODE_PUSH_FRONT = 2'd1,
      MODE_POP_BACK   = 2'd2,
      MODE_POP_FRONT  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_POP_EMPTY = 2'd1,
      ST_PUSH_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FETCH,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic fetch;
   } dq_cmd_type;

   typedef struct packed {
      logic needs_fetch;
   } dq_stat_type;

   function automatic idx_type next_idx(idx_type i);
      return (i == idx_type'(DEPTH - 1)) ? '0 : i + idx_type'(1);
   endfunction

   function automatic idx_type prev_idx(idx_type i);
      return (i == '0) ? idx_type'(DEPTH - 1) : i - idx_type'(1);
   endfunction

endpackage
`default_nettype wire

[design/dq_ctrl.sv]
`default_nettype none
module dq_ctrl import dq_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   input  dq_stat_type stat,
   output dq_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.needs_fetch ? S_FETCH : S_RESP;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

[design/dq_datapath.sv]
`default_nettype none
module dq_datapath import dq_pkg::*; (
   input  wire                clock,
   input  wire                reset,
   input  dq_cmd_type         cmd,
   output dq_stat_type        stat,
   input  wire         [1:0]  req_mode,
   input  wire signed  [31:0] req_push_value,
   output logic signed [31:0] rsp_front_value,
   output logic signed [31:0] rsp_rear_value,
   output logic               rsp_is_empty,
   output logic        [1:0]  rsp_status
);

   logic [31:0] mem [DEPTH];

   mode_type    mode_ff;
   logic [31:0] value_ff;
   idx_type     head_ff, head_in;
   idx_type     tail_ff, tail_in;
   cnt_type     count_ff, count_in;
   logic [31:0] front_ff, front_in;
   logic [31:0] rear_ff, rear_in;
   status_type  status_ff, status_in;
   logic [31:0] rd_ff;
   logic        wr_en;
   idx_type     wr_addr;
   idx_type     rd_addr;
   logic        full;
   logic        empty;

   assign full  = (count_ff == cnt_type'(DEPTH));
   assign empty = (count_ff == '0);

   assign stat.needs_fetch = (mode_ff == MODE_POP_BACK || mode_ff == MODE_POP_FRONT) &&
                             (count_ff > cnt_type'(1));

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      front_in  = front_ff;
      rear_in   = rear_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = tail_ff;
      rd_addr   = next_idx(head_ff);
      if (cmd.exec) begin
         status_in = ST_DONE;
         case (mode_ff)
            MODE_PUSH_BACK: begin
               if (full) begin
                  status_in = ST_PUSH_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = tail_ff;
                  tail_in  = next_idx(tail_ff);
                  count_in = count_ff + cnt_type'(1);
                  rear_in  = value_ff;
                  if (empty) front_in = value_ff;
               end
            end
            MODE_PUSH_FRONT: begin
               if (full) begin
                  status_in = ST_PUSH_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = prev_idx(head_ff);
                  head_in  = prev_idx(head_ff);
                  count_in = count_ff + cnt_type'(1);
                  front_in = value_ff;
                  if (empty) rear_in = value_ff;
               end
            end
            MODE_POP_BACK: begin
               rd_addr = prev_idx(prev_idx(tail_ff));
               if (empty) begin
                  status_in = ST_POP_EMPTY;
               end else begin
                  tail_in  = prev_idx(tail_ff);
                  count_in = count_ff - cnt_type'(1);
               end
            end
            MODE_POP_FRONT: begin
               rd_addr = next_idx(head_ff);
               if (empty) begin
                  status_in = ST_POP_EMPTY;
               end else begin
                  head_in  = next_idx(head_ff);
                  count_in = count_ff - cnt_type'(1);
               end
            end
            default: status_in = ST_DONE;
         endcase
      end
      if (cmd.fetch) begin
         if (mode_ff == MODE_POP_BACK) begin
            rear_in = rd_ff;
         end else begin
            front_in = rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= mode_type'(req_mode);
         value_ff <= req_push_value;
      end
      front_ff  <= front_in;
      rear_ff   <= rear_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rsp_is_empty    = empty;
   assign rsp_front_value = empty ? '0 : front_ff;
   assign rsp_rear_value  = empty ? '0 : rear_ff;
   assign rsp_status      = status_ff;

endmodule
`default_nettype wire

[design/double_ended_queue.sv]
// Bounded deque of signed 32-bit values on a ring buffer of DEPTH entries.
// Request channel (req_valid/req_stall): one beat carries req_mode
// (0 push back, 1 push front, 2 pop back, 3 pop front) and req_push_value.
// Response channel (rsp_valid/rsp_stall): one beat per request with the front
// and rear values after the operation (both 0 when empty), rsp_is_empty and
// rsp_status (0 done, 1 pop on empty ignored, 2 push on full dropped).
// A beat is taken on a rising edge with valid high and stall low.
// The request is loaded on acceptance, executed in S_EXEC and answered in
// S_RESP; a pop that leaves entries behind passes through S_FETCH first,
// which takes the new front or rear from the memory's registered read port.
// One request is in flight at a time: req_stall is high from acceptance until
// the response beat is taken, so no new request is taken before the response
// of the last one is taken. While rsp_stall is high the response holds steady
// and no new request is taken.
// Synchronous active-high reset empties the queue (pointers and count to
// zero) and drops any request in flight; memory contents are not cleared.
`default_nettype none
module double_ended_queue import dq_pkg::*; (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire         [1:0]  req_mode,
   input  wire signed  [31:0] req_push_value,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [31:0] rsp_front_value,
   output logic signed [31:0] rsp_rear_value,
   output logic               rsp_is_empty,
   output logic        [1:0]  rsp_status
);

   dq_cmd_type  cmd;
   dq_stat_type stat;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_mode),
      .req_push_value  (req_push_value),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid)
      else $error("response in cycle after request");

   a_pop_empty_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_POP_EMPTY) |-> rsp_is_empty)
      else $error("pop on empty reported with entries present");

   a_push_full_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_PUSH_FULL) |-> !rsp_is_empty)
      else $error("push on full reported with queue empty");

endmodule
`default_nettype wire

[test/tb_double_ended_queue.sv]
`default_nettype none
module tb_double_ended_queue;
   import dq_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PER_PHASE = 420;

   typedef struct {
      mode_type           mode;
      logic signed [31:0] value;
   } deque_op_type;

   typedef struct {
      logic signed [31:0] front_value;
      logic signed [31:0] rear_value;
      logic               is_empty;
      status_type         status;
   } deque_view_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_mode = MODE_PUSH_BACK;
   logic signed [31:0] req_push_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_front_value;
   logic signed [31:0] rsp_rear_value;
   logic               rsp_is_empty;
   logic [1:0]         rsp_status;

   deque_op_type       op_backlog[$];
   deque_view_type     view_queue[$];
   logic signed [31:0] shadow_slots[DEPTH];
   int                 shadow_head = 0;
   int                 shadow_tail = 0;
   int                 shadow_count = 0;
   int                 sender_idle_pct = 0;
   int                 receiver_stall_pct = 0;
   int                 quiet_cycles = 0;
   bit                 failed = 1'b0;

   double_ended_queue uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_front_value(rsp_front_value),
      .rsp_rear_value (rsp_rear_value),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_status     (rsp_status)
   );

   always #5 clock = ~clock;

   function automatic deque_view_type deque_apply(deque_op_type op);
      deque_view_type v;
      v.status = ST_DONE;
      case (op.mode)
         MODE_PUSH_BACK: begin
            if (shadow_count == DEPTH) begin
               v.status = ST_PUSH_FULL;
            end else begin
               shadow_slots[shadow_tail] = op.value;
               shadow_tail = (shadow_tail + 1) % DEPTH;
               shadow_count++;
            end
         end
         MODE_PUSH_FRONT: begin
            if (shadow_count == DEPTH) begin
               v.status = ST_PUSH_FULL;
            end else begin
               shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
               shadow_slots[shadow_head] = op.value;
               shadow_count++;
            end
         end
         MODE_POP_BACK: begin
            if (shadow_count == 0) begin
               v.status = ST_POP_EMPTY;
            end else begin
               shadow_tail = (shadow_tail + DEPTH - 1) % DEPTH;
               shadow_count--;
            end
         end
         default: begin
            if (shadow_count == 0) begin
               v.status = ST_POP_EMPTY;
            end else begin
               shadow_head = (shadow_head + 1) % DEPTH;
               shadow_count--;
            end
         end
      endcase
      v.is_empty = (shadow_count == 0);
      v.front_value = v.is_empty ? '0 : shadow_slots[shadow_head];
      v.rear_value = v.is_empty ? '0 : shadow_slots[(shadow_tail + DEPTH - 1) % DEPTH];
      return v;
   endfunction

   task automatic queue_op(mode_type m, logic signed [31:0] v);
      deque_op_type op;
      op.mode = m;
      op.value = v;
      op_backlog.push_back(op);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return -32'sd1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   // bursts leaning toward push, toward pop or balanced so the queue swings between full and empty
   task automatic queue_random(int n);
      int left;
      int burst;
      int push_pct;
      left = n;
      while (left > 0) begin
         burst = $urandom_range(24, 1);
         case ($urandom_range(2))
            0: push_pct = 85;
            1: push_pct = 15;
            default: push_pct = 50;
         endcase
         for (int i = 0; i < burst && left > 0; i++) begin
            if ($urandom_range(99) < push_pct) begin
               queue_op($urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, pick_value());
            end else begin
               queue_op($urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK, pick_value());
            end
            left--;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_stall) begin
         // beat held until taken
      end else begin
         if (req_valid) begin
            view_queue.push_back(deque_apply(op_backlog.pop_front()));
         end
         if (op_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_mode <= op_backlog[0].mode;
            req_push_value <= op_backlog[0].value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      deque_view_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (view_queue.size() == 0) begin
               $display("%0t: unexpected rsp beat front %0d rear %0d empty %0b status %0d",
                        $time, rsp_front_value, rsp_rear_value, rsp_is_empty, rsp_status);
               failed = 1'b1;
            end else begin
               want = view_queue.pop_front();
               if (rsp_front_value !== want.front_value) begin
                  $display("%0t: rsp_front_value expected %0d actual %0d",
                           $time, want.front_value, rsp_front_value);
                  failed = 1'b1;
               end
               if (rsp_rear_value !== want.rear_value) begin
                  $display("%0t: rsp_rear_value expected %0d actual %0d",
                           $time, want.rear_value, rsp_rear_value);
                  failed = 1'b1;
               end
               if (rsp_is_empty !== want.is_empty) begin
                  $display("%0t: rsp_is_empty expected %0b actual %0b",
                           $time, want.is_empty, rsp_is_empty);
                  failed = 1'b1;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: rsp_status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  failed = 1'b1;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("double_ended_queue verification failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         @(negedge clock);
         case (phase)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 73;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 73;
            end
            default: begin
               sender_idle_pct = 19;
               receiver_stall_pct = 19;
            end
         endcase
         if (phase == 0) begin
            // pops on empty, extreme values at both ends, then fill and overflow
            queue_op(MODE_POP_BACK, 32'sh7fff_ffff);
            queue_op(MODE_POP_FRONT, 32'sh8000_0000);
            queue_op(MODE_PUSH_BACK, 32'sh8000_0000);
            queue_op(MODE_PUSH_FRONT, 32'sh7fff_ffff);
            queue_op(MODE_POP_FRONT, '0);
            queue_op(MODE_POP_BACK, -32'sd1);
            for (int i = 0; i < DEPTH; i++) begin
               queue_op((i % 2) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, $urandom);
            end
            queue_op(MODE_PUSH_BACK, -32'sd1);
            queue_op(MODE_PUSH_FRONT, '0);
         end
         queue_random(RANDOM_PER_PHASE);
         while (op_backlog.size() > 0 || view_queue.size() > 0) @(negedge clock);
      end
      repeat (8) @(posedge clock);
      if (!failed) begin
         $display("double_ended_queue verification clean");
      end else begin
         $display("double_ended_queue verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
design/dq_pkg.sv
design/dq_ctrl.sv
design/dq_datapath.sv
design/double_ended_queue.sv
test/tb_double_ended_queue.sv
